FILE: hw/rtl/mtrt_pkg.sv
// Shared types and constants for the Modbus TCP read transaction block.
package mtrt_pkg;

    typedef enum logic [1:0]
    {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_code_t;

    localparam logic [1:0] KIND_REQ    = 2'd0;
    localparam logic [1:0] KIND_WORD   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_EXC  = 2'd1;
    localparam logic [1:0] ST_COMM = 2'd2;

    localparam logic [7:0] FC_READ_COILS      = 8'd1;
    localparam logic [7:0] FC_READ_INPUTS     = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING    = 8'd3;
    localparam logic [7:0] FC_READ_INPUT_REGS = 8'd4;

    localparam logic [7:0]  EXC_BIT       = 8'h80;
    localparam logic [7:0]  MBAP_LENGTH   = 8'h06;
    localparam logic [7:0]  HDR_LAST_POS  = 8'd8;
    localparam logic [15:0] MIN_LENGTH    = 16'd3;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [3:0]  REQ_LAST_IDX  = 4'd11;

    typedef struct packed
    {
        logic [1:0]  cmd;
        logic [7:0]  unit_address;
        logic [7:0]  function_code;
        logic [15:0] first_register;
        logic [6:0]  register_count;
        logic [7:0]  rx_byte;
    } in_item_t;

    typedef struct packed
    {
        logic [1:0]  item_kind;
        logic [7:0]  tx_byte;
        logic [15:0] register_value;
        logic [1:0]  status;
        logic [7:0]  exception_code;
        logic        last;
    } out_item_t;

    typedef struct packed
    {
        logic        is_request;
        logic [15:0] txid;
        logic [7:0]  unit_address;
        logic [7:0]  function_code;
        logic [15:0] first_register;
        logic [6:0]  quantity;
        out_item_t   item;
    } job_t;

endpackage

FILE: hw/rtl/mtrt_front.sv
// Front end: tracks the transaction, parses response bytes and queues output jobs.
module mtrt_front #(
    parameter int MAX_REGS = 120
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_wdata,
    input  logic             accept,
    input  mtrt_pkg::in_item_t in_data,
    output logic             push,
    output mtrt_pkg::job_t   job
);
    import mtrt_pkg::*;

    typedef enum logic [1:0]
    {
        PH_IDLE,
        PH_HEADER,
        PH_DATA
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] timeout_reg;
    logic [15:0] counter_reg, counter_next;
    logic [7:0]  pos_reg, pos_next;
    logic [15:0] echoed_reg, echoed_next;
    logic [15:0] length_reg, length_next;
    logic [7:0]  held_reg, held_next;
    logic [6:0]  words_reg, words_next;
    logic        bit_mode_reg, bit_mode_next;
    logic [15:0] idle_reg, idle_next;

    always_comb
    begin
        logic [6:0]  cnt;
        logic        bm;
        logic [15:0] limit;
        logic [15:0] idle_inc;
        logic [7:0]  expect_cnt;
        logic [7:0]  word_index;

        phase_next    = phase_reg;
        counter_next  = counter_reg;
        pos_next      = pos_reg;
        echoed_next   = echoed_reg;
        length_next   = length_reg;
        held_next     = held_reg;
        words_next    = words_reg;
        bit_mode_next = bit_mode_reg;
        idle_next     = idle_reg;
        push          = 1'b0;
        job           = '0;

        bm = (in_data.function_code == FC_READ_COILS) ||
             (in_data.function_code == FC_READ_INPUTS);
        cnt = in_data.register_count;
        if (cnt == 7'd0)
        begin
            cnt = 7'd1;
        end
        if (cnt > 7'(MAX_REGS))
        begin
            cnt = 7'(MAX_REGS);
        end
        limit      = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
        idle_inc   = (idle_reg != 16'hFFFF) ? idle_reg + 16'd1 : idle_reg;
        expect_cnt = bit_mode_reg ? 8'd1 : {words_reg, 1'b0};
        word_index = {1'b0, pos_reg[7:1]};

        if (accept)
        begin
            if (in_data.cmd == CMD_START)
            begin
                bit_mode_next      = bm;
                words_next         = bm ? 7'd1 : cnt;
                counter_next       = counter_reg + 16'd1;
                phase_next         = PH_HEADER;
                pos_next           = 8'd0;
                echoed_next        = 16'd0;
                length_next        = 16'd0;
                held_next          = 8'd0;
                idle_next          = 16'd0;
                push               = 1'b1;
                job.is_request     = 1'b1;
                job.txid           = counter_reg + 16'd1;
                job.unit_address   = in_data.unit_address;
                job.function_code  = in_data.function_code;
                job.first_register = in_data.first_register;
                job.quantity       = bm ? 7'd1 : cnt;
            end
            else if (in_data.cmd == CMD_TICK && phase_reg != PH_IDLE)
            begin
                idle_next = idle_inc;
                if (idle_inc >= limit)
                begin
                    phase_next          = PH_IDLE;
                    push                = 1'b1;
                    job.item.item_kind  = KIND_STATUS;
                    job.item.status     = ST_COMM;
                    job.item.last       = 1'b1;
                end
            end
            else if (in_data.cmd == CMD_BYTE && phase_reg == PH_HEADER)
            begin
                idle_next = 16'd0;
                unique case (pos_reg)
                    8'd0:    echoed_next = {in_data.rx_byte, 8'd0};
                    8'd1:    echoed_next = {echoed_reg[15:8], in_data.rx_byte};
                    8'd4:    length_next = {in_data.rx_byte, 8'd0};
                    8'd5:    length_next = {length_reg[15:8], in_data.rx_byte};
                    8'd7:    held_next = in_data.rx_byte;
                    default: ;
                endcase
                if (pos_reg < HDR_LAST_POS)
                begin
                    pos_next = pos_reg + 8'd1;
                end
                else
                begin
                    job.item.item_kind = KIND_STATUS;
                    job.item.last      = 1'b1;
                    if (echoed_reg != counter_reg || length_reg < MIN_LENGTH)
                    begin
                        phase_next      = PH_IDLE;
                        push            = 1'b1;
                        job.item.status = ST_COMM;
                    end
                    else if ((held_reg & EXC_BIT) != 8'd0)
                    begin
                        phase_next              = PH_IDLE;
                        push                    = 1'b1;
                        job.item.status         = ST_EXC;
                        job.item.exception_code = in_data.rx_byte;
                    end
                    else if (in_data.rx_byte != expect_cnt)
                    begin
                        phase_next      = PH_IDLE;
                        push            = 1'b1;
                        job.item.status = ST_COMM;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                        pos_next   = 8'd0;
                    end
                end
            end
            else if (in_data.cmd == CMD_BYTE && phase_reg == PH_DATA)
            begin
                idle_next = 16'd0;
                if (bit_mode_reg)
                begin
                    phase_next              = PH_IDLE;
                    push                    = 1'b1;
                    job.item.item_kind      = KIND_WORD;
                    job.item.register_value = {15'd0, in_data.rx_byte[0]};
                    job.item.last           = 1'b1;
                end
                else if (!pos_reg[0])
                begin
                    held_next = in_data.rx_byte;
                    pos_next  = pos_reg + 8'd1;
                end
                else
                begin
                    pos_next                = pos_reg + 8'd1;
                    push                    = 1'b1;
                    job.item.item_kind      = KIND_WORD;
                    job.item.register_value = {held_reg, in_data.rx_byte};
                    job.item.last           = (word_index + 8'd1) >= {1'b0, words_reg};
                    if (job.item.last)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            timeout_reg  <= TIMEOUT_RESET;
            counter_reg  <= 16'd0;
            pos_reg      <= 8'd0;
            echoed_reg   <= 16'd0;
            length_reg   <= 16'd0;
            held_reg     <= 8'd0;
            words_reg    <= 7'd0;
            bit_mode_reg <= 1'b0;
            idle_reg     <= 16'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            counter_reg  <= counter_next;
            pos_reg      <= pos_next;
            echoed_reg   <= echoed_next;
            length_reg   <= length_next;
            held_reg     <= held_next;
            words_reg    <= words_next;
            bit_mode_reg <= bit_mode_next;
            idle_reg     <= idle_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

endmodule

FILE: hw/rtl/mtrt_queue.sv
// Small register queue of jobs between the front end and the output sequencer.
module mtrt_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mtrt_pkg::job_t push_data,
    output logic           full,
    output logic           valid,
    output mtrt_pkg::job_t head,
    input  logic           pop
);
    import mtrt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/mtrt_back.sv
// Output sequencer: expands request jobs into 12 bytes and drives the result register.
module mtrt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  mtrt_pkg::job_t    job,
    output logic              pop,
    output logic              res_valid,
    input  logic              res_ready,
    output mtrt_pkg::out_item_t res_data
);
    import mtrt_pkg::*;

    logic      valid_reg, valid_next;
    out_item_t data_reg, data_next;
    logic [3:0] idx_reg, idx_next;
    logic       load;
    logic [7:0] req_byte;

    assign res_valid = valid_reg;
    assign res_data  = data_reg;
    assign load      = job_valid && (!valid_reg || res_ready);

    always_comb
    begin
        unique case (idx_reg)
            4'd0:    req_byte = job.txid[15:8];
            4'd1:    req_byte = job.txid[7:0];
            4'd5:    req_byte = MBAP_LENGTH;
            4'd6:    req_byte = job.unit_address;
            4'd7:    req_byte = job.function_code;
            4'd8:    req_byte = job.first_register[15:8];
            4'd9:    req_byte = job.first_register[7:0];
            4'd11:   req_byte = {1'b0, job.quantity};
            default: req_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = 1'b1;
            if (job.is_request)
            begin
                data_next           = '0;
                data_next.item_kind = KIND_REQ;
                data_next.tx_byte   = req_byte;
                data_next.last      = (idx_reg == REQ_LAST_IDX);
                pop                 = (idx_reg == REQ_LAST_IDX);
                idx_next            = pop ? 4'd0 : idx_reg + 4'd1;
            end
            else
            begin
                data_next = job.item;
                pop       = 1'b1;
            end
        end
        else if (res_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 4'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

FILE: hw/rtl/modbus_tcp_read_transaction_top.sv
// Top level of the Modbus TCP client read transaction block.
// A job pushed by an accepted input passes through the job queue into the result register.
// Throughput: one input transaction per cycle; a start emits 12 request bytes, one per cycle
// while res_ready is high; the front end runs ahead; input stalls only on a full job queue.
// Reset: asynchronous, active low; clears all transaction state and the queue,
// and sets the timeout register to 1000 ticks.
module modbus_tcp_read_transaction_top #(
    parameter int MAX_REGS    = 120,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  mtrt_pkg::in_item_t  cmd_data,
    output logic                res_valid,
    input  logic                res_ready,
    output mtrt_pkg::out_item_t res_data
);
    import mtrt_pkg::*;

    logic full;
    logic push;
    logic pop;
    logic q_valid;
    job_t push_job;
    job_t head_job;

    assign cmd_ready = !full;

    mtrt_front #(
        .MAX_REGS(MAX_REGS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (cmd_valid && cmd_ready),
        .in_data   (cmd_data),
        .push      (push),
        .job       (push_job)
    );

    mtrt_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (full),
        .valid     (q_valid),
        .head      (head_job),
        .pop       (pop)
    );

    mtrt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job       (head_job),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    a_start_queued: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_data.cmd == CMD_START |=> q_valid)
        else $error("start transaction not queued");

    a_word_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.item_kind == KIND_WORD |->
        res_data.status == ST_OK && res_data.tx_byte == 8'd0)
        else $error("register word with bad status or tx byte");

    a_exc_final: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.status == ST_EXC |->
        res_data.item_kind == KIND_STATUS && res_data.last)
        else $error("exception status not on final status item");

endmodule

FILE: tb/modbus_read_checker.sv
// Checker for the Modbus TCP read block: predicts every result and compares it.
`timescale 1ns / 100ps

module modbus_read_checker #(
    parameter int MAX_REGS = 120
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                cmd_valid,
    input  logic                cmd_ready,
    input  mtrt_pkg::in_item_t  cmd_data,
    input  logic                res_valid,
    input  logic                res_ready,
    input  mtrt_pkg::out_item_t res_data,
    output int                  errors,
    output int                  pending,
    output int                  results_seen
);
    import mtrt_pkg::*;

    typedef enum logic [1:0]
    {
        RD_IDLE,
        RD_HEADER,
        RD_DATA
    } read_phase_t;

    out_item_t   awaited[$];
    out_item_t   head_item;
    logic [15:0] timeout_reg;
    logic [15:0] txn_counter;
    read_phase_t rd_phase;
    logic [7:0]  byte_pos;
    logic [15:0] echo_id;
    logic [15:0] length_val;
    logic [7:0]  held_byte;
    logic [6:0]  words_due;
    logic        bit_mode;
    logic [15:0] idle_ticks;

    task automatic note_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        if (errors < 25)
            $display("%0t: mismatch on %s: got %0h, wanted %0h", $time, what, got, want);
        errors++;
    endtask

    function automatic out_item_t result_of(input logic [1:0] kind, input logic [7:0] tx,
                                            input logic [15:0] val, input logic [1:0] st,
                                            input logic [7:0] exc, input logic lst);
        out_item_t r;
        r.item_kind      = kind;
        r.tx_byte        = tx;
        r.register_value = val;
        r.status         = st;
        r.exception_code = exc;
        r.last           = lst;
        return r;
    endfunction

    task automatic close_read(input logic [1:0] st, input logic [7:0] exc);
        rd_phase = RD_IDLE;
        awaited.push_back(result_of(KIND_STATUS, 8'h00, 16'h0000, st, exc, 1'b1));
    endtask

    task automatic advance_client(input in_item_t it);
        logic [6:0]  cnt;
        logic [6:0]  qty;
        logic [15:0] lim;
        logic [95:0] frame;
        logic [7:0]  rx;
        logic        lst;
        rx = it.rx_byte;
        case (cmd_code_t'(it.cmd))
            CMD_START:
            begin
                bit_mode = (it.function_code == FC_READ_COILS ||
                            it.function_code == FC_READ_INPUTS);
                cnt = it.register_count;
                if (cnt == 7'd0)
                    cnt = 7'd1;
                if (int'(cnt) > MAX_REGS)
                    cnt = 7'(MAX_REGS);
                qty = bit_mode ? 7'd1 : cnt;
                words_due = qty;
                txn_counter = txn_counter + 16'd1;
                frame = {txn_counter, 8'h00, 8'h00, 8'h00, MBAP_LENGTH, it.unit_address,
                         it.function_code, it.first_register, 8'h00, 1'b0, qty};
                for (int k = 0; k < 12; k++)
                    awaited.push_back(result_of(KIND_REQ, frame[95 - 8 * k -: 8], 16'h0000,
                                                ST_OK, 8'h00, k == int'(REQ_LAST_IDX)));
                rd_phase = RD_HEADER;
                byte_pos = 8'd0;
                echo_id = 16'h0000;
                length_val = 16'h0000;
                held_byte = 8'h00;
                idle_ticks = 16'h0000;
            end
            CMD_TICK:
            begin
                if (rd_phase != RD_IDLE)
                begin
                    lim = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
                    if (idle_ticks != 16'hFFFF)
                        idle_ticks = idle_ticks + 16'd1;
                    if (idle_ticks >= lim)
                        close_read(ST_COMM, 8'h00);
                end
            end
            CMD_BYTE:
            begin
                if (rd_phase == RD_HEADER)
                begin
                    idle_ticks = 16'h0000;
                    case (byte_pos)
                        8'd0: echo_id = {rx, 8'h00};
                        8'd1: echo_id = echo_id | {8'h00, rx};
                        8'd4: length_val = {rx, 8'h00};
                        8'd5: length_val = length_val | {8'h00, rx};
                        8'd7: held_byte = rx;
                        default: ;
                    endcase
                    if (byte_pos < HDR_LAST_POS)
                        byte_pos = byte_pos + 8'd1;
                    else if (echo_id != txn_counter || length_val < MIN_LENGTH)
                        close_read(ST_COMM, 8'h00);
                    else if ((held_byte & EXC_BIT) != 8'h00)
                        close_read(ST_EXC, rx);
                    else if (rx != (bit_mode ? 8'd1 : {words_due, 1'b0}))
                        close_read(ST_COMM, 8'h00);
                    else
                    begin
                        rd_phase = RD_DATA;
                        byte_pos = 8'd0;
                    end
                end
                else if (rd_phase == RD_DATA)
                begin
                    idle_ticks = 16'h0000;
                    if (bit_mode)
                    begin
                        rd_phase = RD_IDLE;
                        awaited.push_back(result_of(KIND_WORD, 8'h00, {15'd0, rx[0]},
                                                    ST_OK, 8'h00, 1'b1));
                    end
                    else if (!byte_pos[0])
                    begin
                        held_byte = rx;
                        byte_pos = byte_pos + 8'd1;
                    end
                    else
                    begin
                        lst = (int'(byte_pos[7:1]) + 1 >= int'(words_due));
                        byte_pos = byte_pos + 8'd1;
                        if (lst)
                            rd_phase = RD_IDLE;
                        awaited.push_back(result_of(KIND_WORD, 8'h00, {held_byte, rx},
                                                    ST_OK, 8'h00, lst));
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaited.delete();
            errors = 0;
            pending = 0;
            results_seen = 0;
            timeout_reg = TIMEOUT_RESET;
            txn_counter = 16'h0000;
            rd_phase = RD_IDLE;
            byte_pos = 8'd0;
            echo_id = 16'h0000;
            length_val = 16'h0000;
            held_byte = 8'h00;
            words_due = 7'd0;
            bit_mode = 1'b0;
            idle_ticks = 16'h0000;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                results_seen++;
                if (awaited.size() == 0)
                    note_mismatch("unexpected result kind", 16'(res_data.item_kind),
                                  16'h0000);
                else
                begin
                    head_item = awaited.pop_front();
                    if (res_data.item_kind !== head_item.item_kind)
                        note_mismatch("item_kind", 16'(res_data.item_kind),
                                      16'(head_item.item_kind));
                    if (res_data.tx_byte !== head_item.tx_byte)
                        note_mismatch("tx_byte", 16'(res_data.tx_byte),
                                      16'(head_item.tx_byte));
                    if (res_data.register_value !== head_item.register_value)
                        note_mismatch("register_value", res_data.register_value,
                                      head_item.register_value);
                    if (res_data.status !== head_item.status)
                        note_mismatch("status", 16'(res_data.status),
                                      16'(head_item.status));
                    if (res_data.exception_code !== head_item.exception_code)
                        note_mismatch("exception_code", 16'(res_data.exception_code),
                                      16'(head_item.exception_code));
                    if (res_data.last !== head_item.last)
                        note_mismatch("last", 16'(res_data.last), 16'(head_item.last));
                end
            end
            if (cfg_we)
                timeout_reg = cfg_wdata;
            if (cmd_valid && cmd_ready)
                advance_client(cmd_data);
            pending = awaited.size();
        end
    end

endmodule

FILE: tb/tb_modbus_tcp_read_transaction_top.sv
// Testbench top for the Modbus TCP read block: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module tb_modbus_tcp_read_transaction_top;
    import mtrt_pkg::*;

    localparam int MAX_REGS    = 120;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    typedef enum int
    {
        RSP_GOOD,
        RSP_BAD_ID,
        RSP_SHORT_LEN,
        RSP_EXCEPTION,
        RSP_BAD_COUNT,
        RSP_CUT
    } reply_shape_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    in_item_t    cmd_data = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    out_item_t   res_data;

    int          errors;
    int          pending;
    int          results_seen;
    int          burst_left = 0;
    int          ticks_since = 0;
    int          tick_limit = 1000;
    int          sent_total = 0;
    int          phase_items = 0;
    int          reads_started = 0;
    int          quiet_cycles = 0;
    logic [15:0] cur_id = 16'h0000;
    logic        squeeze = 1'b0;
    logic [7:0]  reply[$];

    logic [15:0] phase_timeout [5] = '{16'd0, 16'd3, 16'hFFFF, 16'd1, 16'd12};
    int          phase_budget [5] = '{30, 45, 35, 30, 35};

    modbus_tcp_read_transaction_top #(
        .MAX_REGS(MAX_REGS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd_data(cmd_data),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_data(res_data)
    );

    modbus_read_checker #(
        .MAX_REGS(MAX_REGS)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd_data(cmd_data),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_data(res_data),
        .errors(errors),
        .pending(pending),
        .results_seen(results_seen)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random stall modes, redrawn from time to time; one long hold-off on request
    initial
    begin : sink
        int cyc;
        int mode;
        cyc = 0;
        mode = 0;
        forever
        begin
            @(negedge clk);
            if (squeeze)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                squeeze = 1'b0;
            end
            if (cyc % 50 == 0)
                mode = $urandom_range(0, 3);
            cyc++;
            case (mode)
                0: res_ready <= 1'b1;
                1: res_ready <= ($urandom_range(0, 3) != 0);
                2: res_ready <= ($urandom_range(0, 3) == 0);
                default: res_ready <= (cyc % 8 < 5);
            endcase
        end
    end

    function automatic in_item_t make_item(input cmd_code_t c, input logic [7:0] unit,
                                           input logic [7:0] fc, input logic [15:0] first,
                                           input logic [6:0] count, input logic [7:0] rx);
        in_item_t it;
        it.cmd            = c;
        it.unit_address   = unit;
        it.function_code  = fc;
        it.first_register = first;
        it.register_count = count;
        it.rx_byte        = rx;
        return it;
    endfunction

    // called and returns at a falling edge
    task automatic send_item(input in_item_t it);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                cmd_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
        end
        burst_left--;
        cmd_data <= it;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        @(negedge clk);
        if (it.cmd == CMD_START)
            cur_id = cur_id + 16'd1;
        if (it.cmd == CMD_TICK)
            ticks_since++;
        else if (it.cmd == CMD_START || it.cmd == CMD_BYTE)
            ticks_since = 0;
        phase_items++;
        sent_total++;
    endtask

    task automatic send_tick();
        send_item(make_item(CMD_TICK, 8'($urandom), 8'($urandom), 16'($urandom),
                            7'($urandom), 8'($urandom)));
    endtask

    task automatic run_read(input reply_shape_t shape, input logic [7:0] unit,
                            input logic [7:0] fc, input logic [15:0] first,
                            input logic [6:0] count);
        logic        bitm;
        logic [6:0]  qty;
        logic [15:0] idv;
        logic [15:0] lenv;
        logic [7:0]  nbytes;
        logic [7:0]  b;
        int          keep;
        int          i;
        bitm = (fc == FC_READ_COILS || fc == FC_READ_INPUTS);
        qty = (count == 7'd0) ? 7'd1 : ((int'(count) > MAX_REGS) ? 7'(MAX_REGS) : count);
        if (bitm)
            qty = 7'd1;
        send_item(make_item(CMD_START, unit, fc, first, count, 8'($urandom)));
        reads_started++;
        idv = cur_id;
        if (shape == RSP_BAD_ID)
            idv = idv ^ (16'd1 << $urandom_range(0, 15));
        lenv = 16'((shape == RSP_SHORT_LEN) ? $urandom_range(0, 2)
                                            : $urandom_range(3, 65535));
        nbytes = bitm ? 8'd1 : {qty, 1'b0};
        reply.delete();
        reply.push_back(idv[15:8]);
        reply.push_back(idv[7:0]);
        reply.push_back(8'($urandom));
        reply.push_back(8'($urandom));
        reply.push_back(lenv[15:8]);
        reply.push_back(lenv[7:0]);
        reply.push_back(8'($urandom));
        reply.push_back(shape == RSP_EXCEPTION ? (fc | EXC_BIT) : (fc & ~EXC_BIT));
        if (shape == RSP_EXCEPTION)
            reply.push_back(8'($urandom));
        else if (shape == RSP_BAD_COUNT)
            reply.push_back(nbytes ^ (8'd1 << $urandom_range(0, 7)));
        else
            reply.push_back(nbytes);
        if (shape == RSP_GOOD || shape == RSP_CUT)
        begin
            for (i = 0; i < (bitm ? 1 : 2 * int'(qty)); i++)
            begin
                b = 8'($urandom);
                if ($urandom_range(0, 5) == 0)
                    b = {8{b[0]}};
                reply.push_back(b);
            end
        end
        keep = reply.size();
        if (shape == RSP_CUT)
            keep = $urandom_range(1, reply.size() - 1);
        for (i = 0; i < keep; i++)
        begin
            while ($urandom_range(0, 7) == 0 && ticks_since + 1 < tick_limit)
                send_tick();
            send_item(make_item(CMD_BYTE, 8'($urandom), 8'($urandom), 16'($urandom),
                                7'($urandom), reply[i]));
        end
        // short timeouts: let the truncated read expire
        if (shape == RSP_CUT && tick_limit <= 20)
        begin
            while (ticks_since < tick_limit)
                send_tick();
        end
    endtask

    task automatic random_read(input bit big);
        logic [7:0]   fc;
        logic [6:0]   count;
        reply_shape_t shape;
        int           r;
        r = $urandom_range(0, 9);
        if (r < 3)
            fc = FC_READ_HOLDING;
        else if (r < 5)
            fc = FC_READ_INPUT_REGS;
        else if (r < 7)
            fc = ($urandom_range(0, 1) == 0) ? FC_READ_COILS : FC_READ_INPUTS;
        else
            fc = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 60)
            shape = RSP_GOOD;
        else if (r < 67)
            shape = RSP_BAD_ID;
        else if (r < 74)
            shape = RSP_SHORT_LEN;
        else if (r < 83)
            shape = RSP_EXCEPTION;
        else if (r < 91)
            shape = RSP_BAD_COUNT;
        else
            shape = RSP_CUT;
        if (big)
        begin
            fc = FC_READ_HOLDING;
            count = 7'($urandom_range(12, 20));
            shape = RSP_GOOD;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            // large counts end in the header to keep the run short
            count = 7'($urandom_range(6, 127));
            if (shape == RSP_GOOD || shape == RSP_CUT)
                shape = RSP_BAD_COUNT;
        end
        else
            count = 7'($urandom_range(0, 5));
        run_read(shape, 8'($urandom), fc, 16'($urandom), count);
    endtask

    task automatic random_traffic(input int budget);
        while (phase_items < budget)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(make_item(cmd_code_t'($urandom_range(0, 3)), 8'($urandom),
                                    8'($urandom), 16'($urandom), 7'($urandom),
                                    8'($urandom)));
            else
                random_read(1'b0);
        end
    endtask

    task automatic set_timeout(input logic [15:0] value);
        cmd_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_wdata <= value;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        tick_limit = (value == 16'd0) ? 1 : int'(value);
        phase_items = 0;
    endtask

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // idle commands, restart while pending, bit read, clamped exception read
        send_tick();
        send_item(make_item(CMD_BYTE, 8'hFF, 8'hFF, 16'hFFFF, 7'h7F, 8'hFF));
        send_item(make_item(CMD_NONE, 8'hFF, 8'hFF, 16'hFFFF, 7'h7F, 8'hFF));
        send_item(make_item(CMD_START, 8'hFF, FC_READ_HOLDING, 16'hFFFF, 7'd0, 8'h00));
        run_read(RSP_GOOD, 8'h00, FC_READ_INPUTS, 16'h0000, 7'd127);
        run_read(RSP_EXCEPTION, 8'h5A, FC_READ_INPUT_REGS, 16'h8000, 7'd127);

        squeeze = 1'b1;
        random_read(1'b1);
        random_traffic(phase_items + 60);

        for (int p = 0; p < 5; p++)
        begin
            set_timeout(phase_timeout[p]);
            if (phase_timeout[p] == 16'd0)
                run_read(RSP_CUT, 8'h01, FC_READ_HOLDING, 16'h1234, 7'd2);
            random_traffic(phase_budget[p]);
        end

        cmd_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        $display("%0d commands sent, %0d reads started, six timeout settings incl. 0 and max",
                 sent_total, reads_started);
        $display("%0d results compared, with one long receiver hold-off", results_seen);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/mtrt_pkg.sv
hw/rtl/mtrt_front.sv
hw/rtl/mtrt_queue.sv
hw/rtl/mtrt_back.sv
hw/rtl/modbus_tcp_read_transaction_top.sv
tb/modbus_read_checker.sv
tb/tb_modbus_tcp_read_transaction_top.sv
